[rtl/pic3_pkg.sv]
// ============================================================================
// pic3_pkg
// Shared widths, types and codes for the convex polygon point test.
// ============================================================================
package pic3_pkg;

    localparam int MAX_VERT = 16;
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int VEC_W    = 2 * DIFF_W + 1;
    localparam int PROD_W   = 2 * VEC_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int IDX_W    = $clog2(MAX_VERT);
    localparam int CNT_W    = $clog2(MAX_VERT + 1);
    localparam int MIN_VERT = 3;

    localparam logic [1:0] KIND_NRM = 2'd0;
    localparam logic [1:0] KIND_CRS = 2'd1;
    localparam logic [1:0] KIND_DOT = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] comp;
    } mac_tag_t;

    typedef struct packed {
        logic     valid;
        logic     clr;
        logic     neg;
        logic     last;
        mac_tag_t tag;
    } mac_req_t;

    typedef struct packed {
        logic     valid;
        mac_tag_t tag;
    } mac_res_t;

endpackage

[rtl/pic3_vstore.sv]
// ============================================================================
// pic3_vstore
// Vertex store: one write port, one registered read port.
// ============================================================================
module pic3_vstore
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [pic3_pkg::IDX_W-1:0] waddr,
    input  pic3_pkg::vertex_t          wdata,
    input  logic [pic3_pkg::IDX_W-1:0] raddr,
    output pic3_pkg::vertex_t          rdata
);

    pic3_pkg::vertex_t mem [pic3_pkg::MAX_VERT];
    pic3_pkg::vertex_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pic3_mac.sv]
// ============================================================================
// pic3_mac
// Shared multiply-accumulate unit: registered product, then signed accumulate.
// ============================================================================
module pic3_mac
(
    input  logic                clk,
    input  logic                rst_n,
    input  pic3_pkg::mac_req_t  req,
    input  pic3_pkg::vec_t      op_a,
    input  pic3_pkg::vec_t      op_b,
    output pic3_pkg::mac_res_t  res,
    output pic3_pkg::acc_t      sum
);

    pic3_pkg::mac_req_t             req_reg;
    logic signed [pic3_pkg::PROD_W-1:0] prod_reg;
    pic3_pkg::acc_t                 acc_reg;
    pic3_pkg::acc_t                 acc_next;
    pic3_pkg::acc_t                 prod_ext;
    pic3_pkg::acc_t                 base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
        end
        else
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (req_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        prod_ext = pic3_pkg::ACC_W'(prod_reg);
        base     = req_reg.clr ? '0 : acc_reg;
        acc_next = req_reg.neg ? (base - prod_ext) : (base + prod_ext);
    end

    assign res.valid = req_reg.valid & req_reg.last;
    assign res.tag   = req_reg.tag;
    assign sum       = acc_next;

endmodule

[rtl/point_in_convex_polygon_3d.sv]
// ============================================================================
// point_in_convex_polygon_3d
// Vertex store and edge-by-edge sign test of a point against a convex polygon.
// ============================================================================
// An item is transferred at a rising edge with start high and busy low.
// req_type 0 loads a vertex (first_vertex restarts the polygon); req_type 1
// tests the point coord_x/y/z against the stored polygon.
// Every item yields one result, held on the result ports for one cycle with
// done high; the receiver cannot stall it.
// A vertex load, or a test with fewer than three vertices, answers in the
// cycle after the transfer and leaves busy low, so items may follow every
// cycle. A test with N stored vertices raises busy and answers after these
// steps, all through one shared multiply-accumulate unit: read vertices 0, 1
// and last, six products for the normal, then for each edge read two
// vertices, six products for the edge cross product and three for the dot
// product, and finally settle the verdict.
// Reset empties the polygon (vertex count zero) and returns to idle; the
// store contents are not cleared.
// ============================================================================
module point_in_convex_polygon_3d
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic                     first_vertex,
    input  logic signed [15:0]       coord_x,
    input  logic signed [15:0]       coord_y,
    input  logic signed [15:0]       coord_z,
    output logic                     done,
    output logic                     is_test_result,
    output logic                     inside_res,
    output logic                     polygon_valid,
    output logic                     store_full
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RV0  = 4'd1;
    localparam logic [3:0] S_RV1  = 4'd2;
    localparam logic [3:0] S_RVL  = 4'd3;
    localparam logic [3:0] S_RVB  = 4'd4;
    localparam logic [3:0] S_NRM  = 4'd5;
    localparam logic [3:0] S_ERI  = 4'd6;
    localparam logic [3:0] S_ERJ  = 4'd7;
    localparam logic [3:0] S_ELD  = 4'd8;
    localparam logic [3:0] S_CRS  = 4'd9;
    localparam logic [3:0] S_DOT  = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;

    localparam int IDX_W = pic3_pkg::IDX_W;
    localparam int CNT_W = pic3_pkg::CNT_W;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [2:0]       step_reg;
    logic [IDX_W-1:0] edge_reg;
    logic [CNT_W-1:0] count_reg;
    logic             outside_reg;
    logic             done_reg;
    logic             is_test_reg;
    logic             inside_reg;
    logic             valid_reg;
    logic             full_reg;

    pic3_pkg::vertex_t p_reg;
    pic3_pkg::vertex_t v0_reg;
    pic3_pkg::vertex_t vi_reg;
    pic3_pkg::diff_t   a_reg [3];
    pic3_pkg::diff_t   b_reg [3];
    pic3_pkg::diff_t   e_reg [3];
    pic3_pkg::diff_t   d_reg [3];
    pic3_pkg::vec_t    n_reg [3];
    pic3_pkg::vec_t    c_reg [3];

    pic3_pkg::diff_t   u_sel [3];
    pic3_pkg::diff_t   w_sel [3];
    logic [1:0]        i1;
    logic [1:0]        i2;

    logic              accept;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  edge_nxt;
    logic              last_edge;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    pic3_pkg::vertex_t wdata;
    pic3_pkg::vertex_t rdata;

    pic3_pkg::mac_req_t mreq;
    pic3_pkg::vec_t     op_a;
    pic3_pkg::vec_t     op_b;
    pic3_pkg::mac_res_t mres;
    pic3_pkg::acc_t     msum;
    logic               dot_neg;

    assign accept    = start & ~busy;
    assign busy      = (state_reg != S_IDLE);
    assign count_m1  = count_reg - CNT_W'(1);
    assign last_idx  = count_m1[IDX_W-1:0];
    assign last_edge = (edge_reg == last_idx);
    assign edge_nxt  = last_edge ? '0 : (edge_reg + IDX_W'(1));
    assign dot_neg   = mres.valid && (mres.tag.kind == pic3_pkg::KIND_DOT) &&
                       msum[pic3_pkg::ACC_W-1];

    assign wdata.x = coord_x;
    assign wdata.y = coord_y;
    assign wdata.z = coord_z;

    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        if (accept && !req_type)
        begin
            if (first_vertex)
            begin
                we    = 1'b1;
                waddr = '0;
            end
            else if (count_reg < CNT_W'(pic3_pkg::MAX_VERT))
            begin
                we = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_RV1:   raddr = IDX_W'(1);
            S_RVL:   raddr = last_idx;
            S_ERI:   raddr = edge_reg;
            S_ERJ:   raddr = edge_nxt;
            default: raddr = '0;
        endcase
    end

    pic3_vstore u_vstore
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        case (step_reg[2:1])
            2'd0:
            begin
                i1 = 2'd1;
                i2 = 2'd2;
            end
            2'd1:
            begin
                i1 = 2'd2;
                i2 = 2'd0;
            end
            default:
            begin
                i1 = 2'd0;
                i2 = 2'd1;
            end
        endcase
        if (state_reg == S_NRM)
        begin
            u_sel = a_reg;
            w_sel = b_reg;
        end
        else
        begin
            u_sel = e_reg;
            w_sel = d_reg;
        end
    end

    always_comb
    begin
        mreq = '0;
        op_a = pic3_pkg::VEC_W'(step_reg[0] ? u_sel[i2] : u_sel[i1]);
        op_b = pic3_pkg::VEC_W'(step_reg[0] ? w_sel[i1] : w_sel[i2]);
        if (state_reg == S_NRM || state_reg == S_CRS)
        begin
            mreq.valid          = 1'b1;
            mreq.clr            = ~step_reg[0];
            mreq.neg            = step_reg[0];
            mreq.last           = step_reg[0];
            mreq.tag.kind       = (state_reg == S_NRM) ? pic3_pkg::KIND_NRM
                                                       : pic3_pkg::KIND_CRS;
            mreq.tag.comp       = step_reg[2:1];
        end
        else if (state_reg == S_DOT)
        begin
            op_a                = n_reg[step_reg[1:0]];
            op_b                = c_reg[step_reg[1:0]];
            mreq.valid          = 1'b1;
            mreq.clr            = (step_reg == 3'd0);
            mreq.last           = (step_reg == 3'd2);
            mreq.tag.kind       = pic3_pkg::KIND_DOT;
        end
    end

    pic3_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .op_a  (op_a),
        .op_b  (op_b),
        .res   (mres),
        .sum   (msum)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type &&
                    count_reg >= CNT_W'(pic3_pkg::MIN_VERT))
                begin
                    state_next = S_RV0;
                end
            end
            S_RV0:  state_next = S_RV1;
            S_RV1:  state_next = S_RVL;
            S_RVL:  state_next = S_RVB;
            S_RVB:  state_next = S_NRM;
            S_NRM:  state_next = (step_reg == 3'd5) ? S_ERI : S_NRM;
            S_ERI:  state_next = S_ERJ;
            S_ERJ:  state_next = S_ELD;
            S_ELD:  state_next = S_CRS;
            S_CRS:  state_next = (step_reg == 3'd5) ? S_DOT : S_CRS;
            S_DOT:
            begin
                if (step_reg == 3'd2)
                begin
                    state_next = last_edge ? S_WAIT : S_ERI;
                end
            end
            S_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            edge_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_next != state_reg)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_NRM || state_reg == S_CRS || state_reg == S_DOT)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (state_reg == S_RVB)
            begin
                edge_reg <= '0;
            end
            else if (state_reg == S_DOT && step_reg == 3'd2)
            begin
                edge_reg <= edge_nxt;
            end
            if (accept && !req_type)
            begin
                if (first_vertex)
                begin
                    count_reg <= CNT_W'(1);
                end
                else if (we)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if ((accept && (!req_type || state_next == S_IDLE)) ||
                state_reg == S_WAIT)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg       <= wdata;
            outside_reg <= 1'b0;
            is_test_reg <= req_type;
            inside_reg  <= 1'b0;
            full_reg    <= !req_type && !first_vertex &&
                           (count_reg >= CNT_W'(pic3_pkg::MAX_VERT));
            if (req_type)
            begin
                valid_reg <= (count_reg >= CNT_W'(pic3_pkg::MIN_VERT));
            end
            else if (first_vertex)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= (count_reg >= CNT_W'(pic3_pkg::MIN_VERT - 1));
            end
        end
        else if (dot_neg)
        begin
            outside_reg <= 1'b1;
        end
        if (state_reg == S_WAIT)
        begin
            inside_reg <= ~(outside_reg | dot_neg);
        end

        unique case (state_reg)
            S_RV1:
            begin
                v0_reg <= rdata;
            end
            S_RVL:
            begin
                a_reg[0] <= {rdata.x[15], rdata.x} - {v0_reg.x[15], v0_reg.x};
                a_reg[1] <= {rdata.y[15], rdata.y} - {v0_reg.y[15], v0_reg.y};
                a_reg[2] <= {rdata.z[15], rdata.z} - {v0_reg.z[15], v0_reg.z};
            end
            S_RVB:
            begin
                b_reg[0] <= {rdata.x[15], rdata.x} - {v0_reg.x[15], v0_reg.x};
                b_reg[1] <= {rdata.y[15], rdata.y} - {v0_reg.y[15], v0_reg.y};
                b_reg[2] <= {rdata.z[15], rdata.z} - {v0_reg.z[15], v0_reg.z};
            end
            S_ERJ:
            begin
                vi_reg   <= rdata;
                d_reg[0] <= {p_reg.x[15], p_reg.x} - {rdata.x[15], rdata.x};
                d_reg[1] <= {p_reg.y[15], p_reg.y} - {rdata.y[15], rdata.y};
                d_reg[2] <= {p_reg.z[15], p_reg.z} - {rdata.z[15], rdata.z};
            end
            S_ELD:
            begin
                e_reg[0] <= {rdata.x[15], rdata.x} - {vi_reg.x[15], vi_reg.x};
                e_reg[1] <= {rdata.y[15], rdata.y} - {vi_reg.y[15], vi_reg.y};
                e_reg[2] <= {rdata.z[15], rdata.z} - {vi_reg.z[15], vi_reg.z};
            end
            default:
            begin
            end
        endcase

        if (mres.valid && mres.tag.kind == pic3_pkg::KIND_NRM)
        begin
            n_reg[mres.tag.comp] <= msum[pic3_pkg::VEC_W-1:0];
        end
        if (mres.valid && mres.tag.kind == pic3_pkg::KIND_CRS)
        begin
            c_reg[mres.tag.comp] <= msum[pic3_pkg::VEC_W-1:0];
        end
    end

    assign done           = done_reg;
    assign is_test_result = is_test_reg;
    assign inside_res     = inside_reg;
    assign polygon_valid  = valid_reg;
    assign store_full     = full_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(pic3_pkg::MAX_VERT))
        else $error("vertex count beyond capacity");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> (done && !is_test_result))
        else $error("vertex load without result");

    a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> (count_reg >= CNT_W'(pic3_pkg::MIN_VERT)))
        else $error("test started on invalid polygon");
`endif

endmodule
